[rtl/b64d_pkg.sv]
`default_nettype none
package b64d_pkg;

  // character constants
  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0] SYM62_RST  = 8'h7E;  // '~'
  localparam logic [7:0] SYM63_RST  = 8'h2D;  // '-'
  localparam logic [7:0] NO_SEXTET  = 8'h80;

  // job queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // configuration register indexes
  localparam logic CFG_SYM62 = 1'b0;
  localparam logic CFG_SYM63 = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_LEN  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       final_char;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
    status_t    status;
  } out_word_t;

  // one queued job: up to three results, first byte in the top lane
  typedef struct packed {
    logic [23:0] data;
    logic [1:0]  nres;      // 1..3 results
    logic        bytes_ok;  // results carry bytes
    logic        eom;       // last result closes the message
    status_t     status;
  } job_t;

  function automatic logic [7:0] map_char(input logic [7:0] c,
                                          input logic [7:0] s62,
                                          input logic [7:0] s63);
    logic [7:0] r;
    r = NO_SEXTET;
    if (c == s62)                       r = 8'd62;
    else if (c == s63)                  r = 8'd63;
    else if (c >= 8'h41 && c <= 8'h5A)  r = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A)  r = c - 8'h61 + 8'd26;
    else if (c >= 8'h30 && c <= 8'h39)  r = c - 8'h30 + 8'd52;
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/b64d_front.sv]
`default_nettype none
module b64d_front (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire                cfg_index,
  input  wire [7:0]          cfg_data,
  input  wire                accept,
  input  b64d_pkg::in_word_t in_word,
  output logic               push,
  output b64d_pkg::job_t     job
);
  import b64d_pkg::*;

  logic [7:0]  sym62_r, sym63_r;
  logic [17:0] acc_r, acc_nxt, acc_e;
  logic [1:0]  cnt_r, cnt_nxt, cnt_e;
  logic        pad_r, pad_nxt;
  logic        disc_r, disc_nxt;
  logic [7:0]  sx;
  logic        grp, bad;

  assign sx = map_char(in_word.char_code, sym62_r, sym63_r);

  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    pad_nxt  = pad_r;
    disc_nxt = disc_r;
    acc_e    = acc_r;
    cnt_e    = cnt_r;
    grp      = 1'b0;
    bad      = 1'b0;
    push     = 1'b0;
    job      = '0;
    job.status = ST_OK;
    if (accept) begin
      if (disc_r) begin
        if (in_word.final_char) disc_nxt = 1'b0;
      end else begin
        if (in_word.char_code == PAD_CHAR) begin
          pad_nxt = 1'b1;
        end else if (pad_r || sx == NO_SEXTET) begin
          bad = 1'b1;
        end else if (cnt_r == 2'd3) begin
          grp          = 1'b1;
          job.data     = {acc_r, sx[5:0]};
          job.nres     = 2'd3;
          job.bytes_ok = 1'b1;
          push         = 1'b1;
          acc_e        = '0;
          cnt_e        = 2'd0;
        end else begin
          acc_e = {acc_r[11:0], sx[5:0]};
          cnt_e = 2'(cnt_r + 2'd1);
        end
        acc_nxt = acc_e;
        cnt_nxt = cnt_e;

        if (bad) begin
          push       = 1'b1;
          job        = '0;
          job.nres   = 2'd1;
          job.eom    = 1'b1;
          job.status = ST_BAD_CHAR;
          acc_nxt    = '0;
          cnt_nxt    = 2'd0;
          pad_nxt    = 1'b0;
          disc_nxt   = ~in_word.final_char;
        end else if (in_word.final_char) begin
          push    = 1'b1;
          acc_nxt = '0;
          cnt_nxt = 2'd0;
          pad_nxt = 1'b0;
          unique case (cnt_e)
            2'd0: begin
              job.eom = 1'b1;
              if (!grp) job.nres = 2'd1;
            end
            2'd1: begin
              job.nres   = 2'd1;
              job.eom    = 1'b1;
              job.status = ST_BAD_LEN;
            end
            2'd2: begin
              job.data     = {acc_e[11:4], 16'h0000};
              job.nres     = 2'd1;
              job.bytes_ok = 1'b1;
              job.eom      = 1'b1;
            end
            default: begin
              job.data     = {acc_e[17:10], acc_e[9:2], 8'h00};
              job.nres     = 2'd2;
              job.bytes_ok = 1'b1;
              job.eom      = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym62_r <= SYM62_RST;
      sym63_r <= SYM63_RST;
      acc_r   <= '0;
      cnt_r   <= 2'd0;
      pad_r   <= 1'b0;
      disc_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SYM62: sym62_r <= cfg_data;
          CFG_SYM63: sym63_r <= cfg_data;
          default:   ;
        endcase
      end
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      pad_r  <= pad_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/b64d_queue.sv]
`default_nettype none
module b64d_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  b64d_pkg::job_t  push_job,
  input  wire             pop,
  output b64d_pkg::job_t  head,
  output logic            empty,
  output logic            full
);
  import b64d_pkg::*;

  job_t             mem_r [QDepth];
  logic [QPtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCntW'(QDepth));
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? QPtrW'(wr_r + 1'b1) : wr_r;
    rd_nxt  = pop  ? QPtrW'(rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = QCntW'(cnt_r + 1'b1);
    else if (!push && pop) cnt_nxt = QCntW'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/b64d_back.sv]
`default_nettype none
module b64d_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_empty,
  input  b64d_pkg::job_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output b64d_pkg::out_word_t out_word
);
  import b64d_pkg::*;

  job_t      job_r, job_nxt;
  logic      busy_r, busy_nxt;
  logic      oval_r, oval_nxt;
  out_word_t oword_r, oword_nxt;
  logic      out_free, emit, last;

  assign out_free = ~oval_r | ~out_stall;
  assign emit     = busy_r & out_free;
  assign last     = (job_r.nres == 2'd1);
  assign q_pop    = ~q_empty & (~busy_r | (emit & last));

  always_comb begin
    job_nxt   = job_r;
    busy_nxt  = busy_r;
    oval_nxt  = oval_r;
    oword_nxt = oword_r;
    if (emit) begin
      oval_nxt                 = 1'b1;
      oword_nxt.data_byte      = job_r.data[23:16];
      oword_nxt.byte_valid     = job_r.bytes_ok;
      oword_nxt.end_of_message = last & job_r.eom;
      oword_nxt.status         = job_r.status;
    end else if (out_free) begin
      oval_nxt = 1'b0;
    end
    if (q_pop) begin
      job_nxt  = q_head;
      busy_nxt = 1'b1;
    end else if (emit) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        job_nxt.data = {job_r.data[15:0], 8'h00};
        job_nxt.nres = 2'(job_r.nres - 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    oword_r <= oword_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      oval_r <= oval_nxt;
    end
  end

  assign out_valid = oval_r;
  assign out_word  = oword_r;

endmodule
`default_nettype wire

[rtl/base64_stream_decoder.sv]
// Channel | Direction | Handshake            | Word
// in_     | input     | in_valid / in_stall  | char_code, final_char
// out_    | output    | out_valid / out_stall| data_byte, byte_valid, end_of_message, status
// cfg_    | input     | cfg_we               | cfg_index selects symbol_for_62 / symbol_for_63
//
// One character word is taken per cycle while in_stall is low; a word is decoded in the
// cycle it is accepted and lands in the job queue on the next edge.
// A job holds one to three result words; the back end drains one result per cycle
// unless out_stall holds it, so a full group gives three results for four input words.
// A result passes the job queue, the back end's job register and the output register.
// Reset (rst_n low, synchronous) empties the queue and message state and
// restores the symbol registers to '~' and '-'.
// in_stall rises only when the four-entry job queue is full.
`default_nettype none
module base64_stream_decoder (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  b64d_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  wire                 out_stall,
  output b64d_pkg::out_word_t out_word,
  input  wire                 cfg_we,
  input  wire                 cfg_index,
  input  wire [7:0]           cfg_data
);
  import b64d_pkg::*;

  logic accept;
  logic push, pop, q_empty, q_full;
  job_t push_job, q_head;

  // Front stalls only on a full queue; it never waits on the output side.
  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  // Front: symbol mapping, sextet packing, padding/discard tracking.
  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_word   (in_word),
    .push      (push),
    .job       (push_job)
  );

  // Decouples bursts of three bytes from the character stream.
  b64d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back: serializes each job into result words behind an output register.
  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

[rtl/b64d_checker.sv]
`default_nettype none
module b64d_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input wire                 out_stall,
  input b64d_pkg::out_word_t out_word
);
  import b64d_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result changed while stalled");

  // a result without a byte always closes the message
  a_nobyte_eom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.byte_valid |-> out_word.end_of_message)
    else $error("byte-less result without end of message");

  // errors carry no byte and end the message
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != ST_OK |->
      !out_word.byte_valid && out_word.end_of_message && out_word.data_byte == 8'h00)
    else $error("malformed error result");

  // error code within range
  a_status_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.status == ST_OK || out_word.status == ST_BAD_CHAR ||
                  out_word.status == ST_BAD_LEN)
    else $error("status code out of range");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
`default_nettype wire

[sim/b64d_decode_checker.sv]
module b64d_decode_checker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  b64d_pkg::in_word_t  in_word,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  b64d_pkg::out_word_t out_word,
  input  wire                 cfg_we,
  input  wire                 cfg_index,
  input  wire [7:0]           cfg_data,
  output int                  mismatches,
  output int                  pending_words,
  output int                  live_words,
  output int                  words_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import b64d_pkg::*;

  // decoder state as the block should hold it
  logic [7:0]  sym62, sym63;
  logic [17:0] grp_bits;   // pending sextets, newest in the low bits
  logic [1:0]  grp_cnt;
  logic        pad_seen;
  logic        dropping;

  out_word_t predicted_words[$];

  initial begin
    mismatches    = 0;
    pending_words = 0;
    live_words    = 0;
    words_checked = 0;
  end

  function automatic logic [7:0] sextet_of(input logic [7:0] c);
    if (c == sym62) return 8'd62;
    if (c == sym63) return 8'd63;
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "a" && c <= "z") return c - "a" + 8'd26;
    if (c >= "0" && c <= "9") return c - "0" + 8'd52;
    return NO_SEXTET;
  endfunction

  function automatic void push_result(input logic [7:0] b, input logic v,
                                      input logic eom, input status_t st);
    out_word_t w;
    w.data_byte      = b;
    w.byte_valid     = v;
    w.end_of_message = eom;
    w.status         = st;
    predicted_words.push_back(w);
  endfunction

  function automatic void clear_message();
    grp_bits = '0;
    grp_cnt  = '0;
    pad_seen = 1'b0;
  endfunction

  function automatic void decode_char(input in_word_t w);
    logic [7:0]  sx;
    logic [23:0] grp;
    out_word_t   last;
    int          before_cnt;
    before_cnt = predicted_words.size();
    if (dropping) begin
      if (w.final_char) dropping = 1'b0;
      return;
    end
    live_words++;
    if (w.char_code == PAD_CHAR) begin
      pad_seen = 1'b1;
    end else begin
      sx = pad_seen ? NO_SEXTET : sextet_of(w.char_code);
      if (sx == NO_SEXTET) begin
        push_result(8'h00, 1'b0, 1'b1, ST_BAD_CHAR);
        clear_message();
        dropping = !w.final_char;
        return;
      end
      if (grp_cnt == 2'd3) begin
        grp = {grp_bits, sx[5:0]};
        push_result(grp[23:16], 1'b1, 1'b0, ST_OK);
        push_result(grp[15:8], 1'b1, 1'b0, ST_OK);
        push_result(grp[7:0], 1'b1, 1'b0, ST_OK);
        grp_bits = '0;
        grp_cnt  = '0;
      end else begin
        grp_bits = {grp_bits[11:0], sx[5:0]};
        grp_cnt  = grp_cnt + 2'd1;
      end
    end
    if (!w.final_char) return;
    case (grp_cnt)
      2'd1: push_result(8'h00, 1'b0, 1'b1, ST_BAD_LEN);
      2'd2: push_result(grp_bits[11:4], 1'b1, 1'b1, ST_OK);
      2'd3: begin
        push_result(grp_bits[17:10], 1'b1, 1'b0, ST_OK);
        push_result(grp_bits[9:2], 1'b1, 1'b1, ST_OK);
      end
      default: begin
        // group boundary: tag the last byte of this step, or close empty
        if (predicted_words.size() > before_cnt) begin
          last = predicted_words.pop_back();
          last.end_of_message = 1'b1;
          predicted_words.push_back(last);
        end else begin
          push_result(8'h00, 1'b0, 1'b1, ST_OK);
        end
      end
    endcase
    clear_message();
  endfunction

  function automatic void check_word(input out_word_t got);
    out_word_t want;
    words_checked++;
    if (predicted_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected word: byte %02h valid %0b eom %0b status %0d",
                 $realtime, got.data_byte, got.byte_valid, got.end_of_message,
                 got.status);
      return;
    end
    want = predicted_words.pop_front();
    if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
        got.end_of_message !== want.end_of_message || got.status !== want.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: word mismatch: exp byte %02h valid %0b eom %0b status %0d, %s",
                 $realtime, want.data_byte, want.byte_valid, want.end_of_message,
                 want.status,
                 $sformatf("got byte %02h valid %0b eom %0b status %0d",
                           got.data_byte, got.byte_valid, got.end_of_message,
                           got.status));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      sym62 = SYM62_RST;
      sym63 = SYM63_RST;
      clear_message();
      dropping = 1'b0;
      predicted_words.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SYM62) sym62 = cfg_data;
        else sym63 = cfg_data;
      end
      if (out_valid && !out_stall) check_word(out_word);
      if (in_valid && !in_stall) decode_char(in_word);
    end
    pending_words = predicted_words.size();
  end

endmodule

[sim/tb_base64_stream_decoder.sv]
module tb_base64_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import b64d_pkg::*;

  localparam int NUM_SETS    = 5;   // symbol settings written after the default run
  localparam int PHASE_CHARS = 50;  // decoded (not dropped) words per setting
  localparam int SETTLE      = 8;   // covers the pipe plus margin

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_we    = 1'b0;
  logic      cfg_index = CFG_SYM62;
  logic [7:0] cfg_data = '0;

  int mismatches, pending_words, live_words, words_checked;

  // symbol codes currently loaded, so stimulus can tell legal from illegal
  logic [7:0] cur62, cur63;
  bit         calm_in, calm_out;

  // settings after the reset default: plain +/, both extremes each way,
  // '=' in a register (padding must still win), and both registers equal
  logic [7:0] set62[NUM_SETS] = '{"+", 8'h00, 8'hFF, PAD_CHAR, "a"};
  logic [7:0] set63[NUM_SETS] = '{"/", 8'hFF, 8'h00, "A", "a"};

  always #6 clk = ~clk;

  base64_stream_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  b64d_decode_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending_words (pending_words),
    .live_words    (live_words),
    .words_checked (words_checked)
  );

  // legal alphabet under the loaded symbols; '=' never counts as a symbol
  function automatic bit is_symbol(input logic [7:0] c);
    return c != PAD_CHAR && (c == cur62 || c == cur63 ||
           (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9"));
  endfunction

  function automatic logic [7:0] any_symbol();
    logic [7:0] c;
    // lean on the two register symbols, the generic draw rarely hits them
    if ($urandom_range(0, 7) == 0) begin
      c = $urandom_range(0, 1) ? cur62 : cur63;
      if (c != PAD_CHAR) return c;
    end
    do c = 8'($urandom_range(0, 255)); while (!is_symbol(c));
    return c;
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_symbol(c) || c == PAD_CHAR);
    return c;
  endfunction

  // One word on the input channel. Gap first, then hold until accepted.
  // in_stall is read 1 ns after the falling edge, where it has settled and
  // holds the value the next rising edge will see.
  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    bit stalled;
    @(negedge clk);
    if ($urandom_range(0, 29) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{char_code: c, final_char: fin};
    do begin
      #1 stalled = (in_stall !== 1'b0);
      @(posedge clk);
      if (stalled) @(negedge clk);
    end while (stalled);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Random message. Mostly well-formed with proper padding, some broken
  // (bad character or data after '=', then a tail that must be dropped),
  // and some raw noise with stray final flags.
  task automatic send_message();
    in_word_t msg[$];
    in_word_t w;
    int       kind, n, pads, tail;
    kind = $urandom_range(0, 99);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 9);
    if (kind < 85) begin
      // a single leftover sextet is a length error; keep it occasional
      if (n % 4 == 1 && $urandom_range(0, 3) != 0) n++;
      for (int i = 0; i < n; i++) msg.push_back('{any_symbol(), 1'b0});
      if (kind >= 65) begin
        if ($urandom_range(0, 1)) begin
          msg.push_back('{bad_char(), 1'b0});
        end else begin
          msg.push_back('{PAD_CHAR, 1'b0});
          msg.push_back('{any_symbol(), 1'b0});
        end
        tail = $urandom_range(0, 4);
        for (int i = 0; i < tail; i++)
          msg.push_back('{8'($urandom_range(0, 255)), 1'b0});
      end else begin
        pads = (n % 4 == 2) ? 2 : (n % 4 == 3) ? 1 : 0;
        if ($urandom_range(0, 4) == 0) pads = $urandom_range(0, 3);
        for (int i = 0; i < pads; i++) msg.push_back('{PAD_CHAR, 1'b0});
      end
      if (msg.size() == 0) msg.push_back('{PAD_CHAR, 1'b0});
      w = msg.pop_back();
      w.final_char = 1'b1;
      msg.push_back(w);
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        msg.push_back('{8'($urandom_range(0, 255)), 1'($urandom_range(0, 5) == 0)});
    end
    foreach (msg[i]) send_char(msg[i].char_code, msg[i].final_char);
  endtask

  // Hold off the sender until every predicted word has come out, then give
  // dropped words (which owe nothing) time to leave the pipe.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Both registers back to back; write enable stays high across the pair.
  task automatic load_symbols(input logic [7:0] s62, input logic [7:0] s63);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYM62;
    cfg_data  <= s62;
    @(negedge clk);
    cfg_index <= CFG_SYM63;
    cfg_data  <= s63;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur62 = s62;
    cur63 = s63;
  endtask

  // Result side: a fresh stall draw per word, then take the word.
  initial begin : result_sink
    int hold;
    bit seen;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 29) == 0) calm_out = !calm_out;
      hold = calm_out ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do begin
        #1 seen = (out_valid === 1'b1);
        @(posedge clk);
        if (!seen) @(negedge clk);
      end while (!seen);
    end
  end

  initial begin : stimulus
    int  target;
    bit  paused;
    paused = 1'b0;
    cur62  = SYM62_RST;
    cur63  = SYM63_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset symbols '~' and '-'
    send_text("TWFu");    // full group, eom lands on its third byte
    send_text("QQ==");    // two sextets then padding, one byte
    send_text("QUI");     // three sextets, two bytes
    send_text("Q");       // lone sextet: length error
    send_text("=");       // padding only: empty end
    send_text("09-~");    // digits and both symbols, top sextet values
    send_char("*", 1'b0); // illegal mid-message, the rest is dropped
    send_char("A", 1'b0);
    send_char("B", 1'b1); // final while dropping, no result
    send_text("QQ=A");    // data after padding is illegal, on the final word
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);

    target = live_words;
    for (int p = 0; p <= NUM_SETS; p++) begin
      if (p > 0) begin
        drain();
        load_symbols(set62[p-1], set63[p-1]);
      end
      target += PHASE_CHARS;
      while (live_words < target) begin
        send_message();
        // one extra full drain partway through the default setting
        if (p == 0 && !paused && live_words >= target - PHASE_CHARS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end
    drain();

    $display("Decoded %0d characters under %0d symbol settings, %0d result words seen.",
             live_words, NUM_SETS + 1, words_checked);
    if (mismatches == 0 && pending_words == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d words still owed", mismatches, pending_words);
      $display("CHECK FAILED");
    end
    $finish;
  end

  // worst case is well under a millisecond; this only catches a hang
  initial begin : watchdog
    #5_000_000;
    $display("Run timed out, %0d words still owed", pending_words);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
